FILE: hdl/tvse_pkg.sv
`default_nettype none
package tvse_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W = 64;
    localparam int BYTE_W = 8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef logic [1:0] action_t;
    localparam action_t ACT_SET_POS = 2'd0;
    localparam action_t ACT_HEADER  = 2'd1;
    localparam action_t ACT_CONTENT = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t STS_OK          = 2'd0;
    localparam status_t STS_NO_HDR_ROOM = 2'd1;
    localparam status_t STS_NO_ROOM     = 2'd2;
    localparam status_t STS_EXCESS      = 2'd3;

    // varint header layout
    localparam int VARINT_FIRST_BITS = 5;
    localparam int VARINT_NEXT_BITS = 7;
    localparam logic [1:0] STRING_WIRE_TYPE = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_ROOM1 = 5'b00100,
        ST_ROOM2 = 5'b01000,
        ST_FINAL = 5'b10000
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/tagged_varint_string_encoder.sv
`default_nettype none
// Length-prefixed string encoder with a tagged base-128 varint header.
// Input beats arrive on s_* (action in s_tuser, length and content byte in
// s_tdata); every result leaves on m_* with m_tlast on the final result of
// an item. The buffer capacity is loaded over cfg_*, which is always ready.
// One item is in work at a time: s_tready is high only while the sequencer
// is idle. A set-position, unused or content item puts its single result in
// the output register from ST_FINAL or ST_CHECK once the register is free,
// and the sequencer then returns to idle. A header item emits one varint
// byte per cycle while the output register is free (each byte checked
// against the capacity by the shared subtractor); its final byte is held
// through ST_ROOM1 and ST_ROOM2 while the same subtractor computes the
// remaining room, and goes out with the item's m_tlast.
// When the receiver stalls, the result stays in the output register and the
// sequencer holds until the register is free, so nothing is lost.
// Reset clears the write position and any pending string and sets the
// capacity to all ones.
module tagged_varint_string_encoder (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // string_length[63:0], content_byte[71:64]
    input  wire  [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // out_byte[7:0], write_address[39:8]
    output logic [2:0]  m_tuser,   // byte_valid[0], status[2:1]
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data
);
    import tvse_pkg::*;

    state_t  state_reg, state_next;
    word_t   cap_reg, cap_next;
    word_t   wp_reg, wp_next;
    word_t   left_reg, left_next;
    logic    blocked_reg, blocked_next;
    action_t act_reg, act_next;
    len_t    len_reg, len_next;
    len_t    v_reg, v_next;
    logic    first_reg, first_next;
    byte_t   ch_reg, ch_next;
    byte_t   pend_reg, pend_next;
    word_t   room_reg, room_next;

    logic    mv_reg, mv_next;
    byte_t   ob_reg, ob_next;
    word_t   oa_reg, oa_next;
    logic    obv_reg, obv_next;
    logic    ol_reg, ol_next;
    status_t os_reg, os_next;

    word_t   alu_a, alu_b, alu_diff;
    logic    alu_ge;
    logic    slot_free;
    logic    more;
    byte_t   hdr_byte;
    len_t    v_shift;
    len_t    in_len;
    word_t   in_sat;
    logic    over;

    tvse_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    assign in_len    = s_tdata[LEN_W-1:0];
    assign in_sat    = (in_len[LEN_W-1:WORD_W] != '0) ? '1 : in_len[WORD_W-1:0];
    assign slot_free = ~mv_reg | m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_tvalid = mv_reg;
    assign m_tdata  = {oa_reg, ob_reg};
    assign m_tuser  = {os_reg, obv_reg};
    assign m_tlast  = ol_reg;

    // next varint byte and the value left after it
    always_comb
    begin
        if (first_reg)
        begin
            more     = (v_reg[LEN_W-1:VARINT_FIRST_BITS] != '0);
            hdr_byte = {STRING_WIRE_TYPE, more, v_reg[VARINT_FIRST_BITS-1:0]};
            v_shift  = v_reg >> VARINT_FIRST_BITS;
        end
        else
        begin
            more     = (v_reg[LEN_W-1:VARINT_NEXT_BITS] != '0);
            hdr_byte = {more, v_reg[VARINT_NEXT_BITS-1:0]};
            v_shift  = v_reg >> VARINT_NEXT_BITS;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_ROOM1:
            begin
                alu_a = cap_reg;
                alu_b = wp_reg;
            end
            ST_ROOM2:
            begin
                alu_a = len_reg[WORD_W-1:0];
                alu_b = room_reg;
            end
            default:
            begin
                alu_a = wp_reg;
                alu_b = cap_reg;
            end
        endcase
    end

    // remaining room is cap - wp - 1 after the final byte: len > that iff len >= cap - wp
    assign over = (len_reg[LEN_W-1:WORD_W] != '0) | alu_ge;

    always_comb
    begin
        state_next   = state_reg;
        cap_next     = cfg_valid ? cfg_data : cap_reg;
        wp_next      = wp_reg;
        left_next    = left_reg;
        blocked_next = blocked_reg;
        act_next     = act_reg;
        len_next     = len_reg;
        v_next       = v_reg;
        first_next   = first_reg;
        ch_next      = ch_reg;
        pend_next    = pend_reg;
        room_next    = room_reg;

        mv_next  = mv_reg & ~m_tready;
        ob_next  = ob_reg;
        oa_next  = oa_reg;
        obv_next = obv_reg;
        ol_next  = ol_reg;
        os_next  = os_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = s_tuser;
                    len_next   = in_len;
                    v_next     = in_len;
                    first_next = 1'b1;
                    ch_next    = s_tdata[LEN_W+BYTE_W-1:LEN_W];
                    if (s_tuser == ACT_HEADER)
                    begin
                        left_next    = in_sat;
                        blocked_next = 1'b0;
                        state_next   = ST_CHECK;
                    end
                    else if (s_tuser == ACT_CONTENT)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        if (s_tuser == ACT_SET_POS)
                        begin
                            wp_next      = in_sat;
                            left_next    = '0;
                            blocked_next = 1'b0;
                        end
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_CHECK:
            begin
                if (act_reg == ACT_HEADER)
                begin
                    if (alu_ge)
                    begin
                        if (slot_free)
                        begin
                            mv_next      = 1'b1;
                            ob_next      = '0;
                            oa_next      = wp_reg;
                            obv_next     = 1'b0;
                            ol_next      = 1'b1;
                            os_next      = STS_NO_HDR_ROOM;
                            blocked_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    else if (!more)
                    begin
                        // final byte waits for the room check
                        pend_next  = hdr_byte;
                        state_next = ST_ROOM1;
                    end
                    else if (slot_free)
                    begin
                        mv_next    = 1'b1;
                        ob_next    = hdr_byte;
                        oa_next    = wp_reg;
                        obv_next   = 1'b1;
                        ol_next    = 1'b0;
                        os_next    = STS_OK;
                        wp_next    = wp_reg + 1'b1;
                        v_next     = v_shift;
                        first_next = 1'b0;
                    end
                end
                else if (slot_free)
                begin
                    mv_next    = 1'b1;
                    ob_next    = '0;
                    oa_next    = wp_reg;
                    obv_next   = 1'b0;
                    ol_next    = 1'b1;
                    state_next = ST_IDLE;
                    if (left_reg == '0)
                    begin
                        os_next = STS_EXCESS;
                    end
                    else
                    begin
                        left_next = left_reg - 1'b1;
                        if (blocked_reg || alu_ge)
                        begin
                            os_next = STS_NO_ROOM;
                        end
                        else
                        begin
                            ob_next  = ch_reg;
                            obv_next = 1'b1;
                            os_next  = STS_OK;
                            wp_next  = wp_reg + 1'b1;
                        end
                        if (left_reg == word_t'(1))
                        begin
                            blocked_next = 1'b0;
                        end
                    end
                end
            end
            ST_ROOM1:
            begin
                room_next  = alu_diff;
                state_next = ST_ROOM2;
            end
            ST_ROOM2:
            begin
                if (slot_free)
                begin
                    mv_next      = 1'b1;
                    ob_next      = pend_reg;
                    oa_next      = wp_reg;
                    obv_next     = 1'b1;
                    ol_next      = 1'b1;
                    os_next      = over ? STS_NO_ROOM : STS_OK;
                    blocked_next = over;
                    wp_next      = wp_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (slot_free)
                begin
                    mv_next    = 1'b1;
                    ob_next    = '0;
                    oa_next    = wp_reg;
                    obv_next   = 1'b0;
                    ol_next    = 1'b1;
                    os_next    = STS_OK;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= '1;
            wp_reg      <= '0;
            left_reg    <= '0;
            blocked_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            wp_reg      <= wp_next;
            left_reg    <= left_next;
            blocked_reg <= blocked_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        len_reg   <= len_next;
        v_reg     <= v_next;
        first_reg <= first_next;
        ch_reg    <= ch_next;
        pend_reg  <= pend_next;
        room_reg  <= room_next;
        ob_reg    <= ob_next;
        oa_reg    <= oa_next;
        obv_reg   <= obv_next;
        ol_reg    <= ol_next;
        os_reg    <= os_next;
    end

endmodule
`default_nettype wire

FILE: hdl/tvse_alu.sv
`default_nettype none
module tvse_alu (
    input  wire tvse_pkg::word_t a,
    input  wire tvse_pkg::word_t b,
    output tvse_pkg::word_t      diff,
    output logic                 ge
);
    import tvse_pkg::*;

    logic [WORD_W:0] full;

    // one subtractor serves the capacity and room compares and the room computation
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[WORD_W-1:0];
    assign ge   = ~full[WORD_W];

endmodule
`default_nettype wire

FILE: tb/tvse_scoreboard_pkg.sv
package tvse_scoreboard_pkg;
    import tvse_pkg::*;

    // one result beat as seen on the master side
    typedef struct packed {
        byte_t   data;
        word_t   addr;
        logic    valid;
        logic    last;
        status_t status;
    } enc_beat_t;

    // action code the block ignores
    localparam action_t ACT_UNUSED = 2'd3;

    class encoder_scoreboard;
        word_t     capacity;
        word_t     wpos;
        word_t     content_left;
        bit        content_blocked;
        enc_beat_t expected_beats[$];
        int        errors;
        int        beats_checked;
        int        items_seen;
        int        status_seen[4];

        function new();
            capacity = '1;
            wpos = '0;
            content_left = '0;
            content_blocked = 1'b0;
            errors = 0;
            beats_checked = 0;
            items_seen = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function enc_beat_t make_beat(byte_t data, word_t addr, logic valid, logic last,
                                      status_t status);
            enc_beat_t b;
            b.data = data;
            b.addr = addr;
            b.valid = valid;
            b.last = last;
            b.status = status;
            return b;
        endfunction

        function word_t sat32(len_t v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function void predict_header(len_t len);
            len_t      rest;
            byte_t     code;
            logic      more;
            bit        first;
            bit        have_held;
            enc_beat_t held;
            word_t     room;
            content_left = sat32(len);
            content_blocked = 1'b0;
            rest = len;
            more = (rest >> VARINT_FIRST_BITS) != 0;
            code = {STRING_WIRE_TYPE, more, rest[VARINT_FIRST_BITS-1:0]};
            first = 1'b1;
            have_held = 1'b0;
            while (1)
            begin
                if (have_held)
                    expected_beats.push_back(held);
                // header byte beyond capacity ends the item
                if (wpos >= capacity)
                begin
                    expected_beats.push_back(make_beat('0, wpos, 1'b0, 1'b1, STS_NO_HDR_ROOM));
                    content_blocked = 1'b1;
                    return;
                end
                held = make_beat(code, wpos, 1'b1, 1'b0, STS_OK);
                have_held = 1'b1;
                wpos++;
                rest = first ? (rest >> VARINT_FIRST_BITS) : (rest >> VARINT_NEXT_BITS);
                first = 1'b0;
                if (rest == 0)
                    break;
                more = (rest >> VARINT_NEXT_BITS) != 0;
                code = {more, rest[VARINT_NEXT_BITS-1:0]};
            end
            held.last = 1'b1;
            room = capacity - wpos;
            if (len > len_t'(room))
            begin
                held.status = STS_NO_ROOM;
                content_blocked = 1'b1;
            end
            expected_beats.push_back(held);
        endfunction

        function void predict_content(byte_t ch);
            if (content_left == 0)
            begin
                expected_beats.push_back(make_beat('0, wpos, 1'b0, 1'b1, STS_EXCESS));
                return;
            end
            content_left--;
            if (content_blocked || wpos >= capacity)
                expected_beats.push_back(make_beat('0, wpos, 1'b0, 1'b1, STS_NO_ROOM));
            else
            begin
                expected_beats.push_back(make_beat(ch, wpos, 1'b1, 1'b1, STS_OK));
                wpos++;
            end
            if (content_left == 0)
                content_blocked = 1'b0;
        endfunction

        function void note_item(action_t act, len_t len, byte_t ch);
            items_seen++;
            case (act)
                ACT_SET_POS:
                begin
                    wpos = sat32(len);
                    content_left = '0;
                    content_blocked = 1'b0;
                    expected_beats.push_back(make_beat('0, wpos, 1'b0, 1'b1, STS_OK));
                end
                ACT_HEADER:
                    predict_header(len);
                ACT_CONTENT:
                    predict_content(ch);
                default:
                    expected_beats.push_back(make_beat('0, wpos, 1'b0, 1'b1, STS_OK));
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(byte_t data, word_t addr, logic valid, logic last, status_t status);
            enc_beat_t e;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("unexpected beat byte %02h addr %08h", data, addr));
                return;
            end
            e = expected_beats.pop_front();
            beats_checked++;
            status_seen[e.status]++;
            if (data !== e.data)
                report($sformatf("beat %0d out_byte %02h, want %02h", beats_checked, data,
                                 e.data));
            if (addr !== e.addr)
                report($sformatf("beat %0d write_address %08h, want %08h", beats_checked, addr,
                                 e.addr));
            if (valid !== e.valid)
                report($sformatf("beat %0d byte_valid %b, want %b", beats_checked, valid,
                                 e.valid));
            if (last !== e.last)
                report($sformatf("beat %0d last %b, want %b", beats_checked, last, e.last));
            if (status !== e.status)
                report($sformatf("beat %0d status %0d, want %0d", beats_checked, status,
                                 e.status));
        endtask

        function int outstanding();
            return expected_beats.size();
        endfunction

        task check_leftover();
            if (expected_beats.size() != 0)
                report($sformatf("%0d beats never arrived", expected_beats.size()));
        endtask
    endclass

endpackage

FILE: tb/tb.sv
module tb;
    import tvse_pkg::*;
    import tvse_scoreboard_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 20;
    localparam int PHASE_ITEMS = 14;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // string_length[63:0], content_byte[71:64]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_byte[7:0], write_address[39:8]
    logic [2:0]  m_tuser;   // byte_valid[0], status[2:1]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    encoder_scoreboard sb;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int cfg_writes = 0;
    int idle_cycles = 0;

    tagged_varint_string_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // monitor: every accepted beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[7:0], m_tdata[39:8], m_tuser[0], m_tlast, m_tuser[2:1]);
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[63:0], s_tdata[71:64]);
            if (cfg_valid && cfg_ready)
                sb.capacity = cfg_data;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver with random stalls
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = rx_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    function automatic len_t wide_len();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic len_t pick_position();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return len_t'($urandom_range(0, 40));
            2: return len_t'(sb.capacity - word_t'($urandom_range(0, 12)));
            default: return wide_len();
        endcase
    endfunction

    task automatic send_item(action_t act, len_t len, byte_t ch);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {ch, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_content(int count);
        repeat (count)
            send_item(ACT_CONTENT, wide_len(), byte_t'($urandom));
    endtask

    // wait until every expected beat is back and the sequencer has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(word_t value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_directed();
        send_item(ACT_SET_POS, 64'd0, 8'h00);
        send_item(ACT_HEADER, 64'd3, 8'hFF);
        send_item(ACT_CONTENT, 64'd0, 8'h00);
        send_item(ACT_CONTENT, '1, 8'hFF);
        send_item(ACT_CONTENT, 64'd0, 8'h5A);
        // one byte more than announced
        send_item(ACT_CONTENT, 64'd0, 8'h33);
        send_item(ACT_HEADER, 64'd0, 8'h00);
        send_item(ACT_HEADER, 64'd31, 8'h00);
        send_item(ACT_HEADER, 64'd32, 8'h00);
        // ten-byte varint, length far beyond the room left
        send_item(ACT_HEADER, '1, 8'h00);
        send_item(ACT_CONTENT, 64'd0, 8'h11);
        send_item(ACT_UNUSED, '1, 8'hFF);
        // position saturates, header then finds no room
        send_item(ACT_SET_POS, '1, 8'h00);
        send_item(ACT_HEADER, 64'd1, 8'h00);
        send_item(ACT_CONTENT, 64'd0, 8'h22);
        send_item(ACT_CONTENT, 64'd0, 8'h44);
        send_item(ACT_SET_POS, 64'd100, 8'h00);
        send_item(ACT_HEADER, 64'd5, 8'h00);
        send_item(ACT_CONTENT, 64'd0, 8'hAA);
        // new position cancels the open string
        send_item(ACT_SET_POS, 64'd200, 8'h00);
        send_item(ACT_CONTENT, 64'd0, 8'h55);
        // capacity shrinks under an open string
        drain();
        write_capacity(32'hFFFF_FFFF);
        send_item(ACT_SET_POS, 64'd0, 8'h00);
        send_item(ACT_HEADER, 64'd20, 8'h00);
        send_content(3);
        drain();
        write_capacity(32'd3);
        send_content(2);
    endtask

    task automatic run_random(int n);
        int      done_items;
        int      count;
        len_t    len;
        action_t act;
        done_items = 0;
        while (done_items < n)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_item(ACT_SET_POS, pick_position(), byte_t'($urandom));
                    done_items++;
                end
                1:
                begin
                    act = action_t'($urandom_range(0, 3));
                    send_item(act, wide_len(), byte_t'($urandom));
                    if (act != ACT_UNUSED)
                        done_items++;
                end
                2:
                begin
                    // length right at the edge of the room left
                    len = len_t'(sb.capacity) - len_t'(sb.wpos) - 64'd2 +
                          len_t'($urandom_range(0, 3));
                    count = $urandom_range(0, 3);
                    send_item(ACT_HEADER, len, byte_t'($urandom));
                    send_content(count);
                    done_items += count + 1;
                end
                9:
                begin
                    len = len_t'($urandom_range(13, 300));
                    count = $urandom_range(0, 8);
                    send_item(ACT_HEADER, len, byte_t'($urandom));
                    send_content(count);
                    done_items += count + 1;
                end
                default:
                begin
                    len = len_t'($urandom_range(0, 12));
                    count = int'(len);
                    if ($urandom_range(0, 3) == 0)
                        count = count + $urandom_range(0, 2) - 1;
                    if (count < 0)
                        count = 0;
                    send_item(ACT_HEADER, len, byte_t'($urandom));
                    send_content(count);
                    done_items += count + 1;
                end
            endcase
        end
    endtask

    initial
    begin
        word_t phase_caps[6];
        sb = new();
        phase_caps[0] = 32'd0;
        phase_caps[1] = 32'd1;
        phase_caps[2] = 32'd24;
        phase_caps[3] = 32'd300;
        phase_caps[4] = $urandom;
        phase_caps[5] = 32'hFFFF_FFFF;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_SET_POS;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        foreach (phase_caps[p])
        begin
            drain();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            write_capacity(phase_caps[p]);
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (END_CYCLES) @(posedge clk);
        sb.check_leftover();
        $display("covered %0d items and %0d result beats over %0d capacity settings",
                 sb.items_seen, sb.beats_checked, cfg_writes);
        $display("beats by status: ok %0d, header refused %0d, content refused %0d, excess %0d",
                 sb.status_seen[STS_OK], sb.status_seen[STS_NO_HDR_ROOM],
                 sb.status_seen[STS_NO_ROOM], sb.status_seen[STS_EXCESS]);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
